// File: rtl/core/etfd_pkg.sv
package etfd_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned PAYLOAD_LEN = FRAME_BYTES - 1;
   localparam int unsigned POS_W       = 4;

   localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_CRC     = POS_W'(PAYLOAD_LEN);
   localparam logic [7:0]       CRC_POLY    = 8'h07;
   localparam logic [7:0]       CRC_INIT    = 8'h00;

   typedef struct packed {
      logic        valid;
      logic [7:0]  temperature_deg;
      logic [15:0] voltage_centivolts;
      logic [15:0] current_centiamps;
      logic [15:0] consumption_mah;
      logic [15:0] rpm_hundreds;
   } result_type;

endpackage

// File: rtl/core/esc_telemetry_frame_decoder.sv
// Telemetry frame decoder for a serial ESC link.
// Request channel: one received byte per request (req_rx_byte) with
// req_frame_start marking the first byte after a line-idle gap. A start
// byte always restarts the frame. Ten bytes form a frame: nine payload
// bytes and a CRC-8 (poly 0x07, init 0) byte. A good frame produces one
// response with temperature from one byte, and voltage, current,
// consumption and rpm from big-endian pairs; a bad frame produces nothing.
// Throughput: one request per cycle while req_stall is low, set by the
// per-byte CRC update. A response appears on rsp_* once the request
// carrying the CRC byte has passed the request register and then the
// response register. Bytes that complete no frame produce no response.
// Stall: while rsp_stall holds a waiting response, the held request byte
// waits too, and req_stall rises once the request register is occupied.
// Reset: synchronous, active high; the block goes idle and ignores bytes
// until the next start byte. Response payload holds while stalled.
module esc_telemetry_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_temperature_deg,
   output logic [15:0] rsp_voltage_centivolts,
   output logic [15:0] rsp_current_centiamps,
   output logic [15:0] rsp_consumption_mah,
   output logic [15:0] rsp_rpm_hundreds
);

   logic                 in_vld_ff;
   logic                 in_vld_in;
   logic [7:0]           in_byte_ff;
   logic                 in_start_ff;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   etfd_pkg::result_type result;
   etfd_pkg::result_type out_ff;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance ? result.valid : (out_vld_ff && rsp_stall);

   etfd_frame_asm u_frame_asm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_temperature_deg    = out_ff.temperature_deg;
   assign rsp_voltage_centivolts = out_ff.voltage_centivolts;
   assign rsp_current_centiamps  = out_ff.current_centiamps;
   assign rsp_consumption_mah    = out_ff.consumption_mah;
   assign rsp_rpm_hundreds       = out_ff.rpm_hundreds;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff)
      else $error("request stalled with free path");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |=> out_vld_ff && $stable(out_ff))
      else $error("waiting response overwritten");

   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(advance) && $past(result.valid))
      else $error("response without processed check byte");
`endif

endmodule

// File: rtl/core/etfd_crc8.sv
module etfd_crc8 (
   input  logic [7:0] crc,
   input  logic [7:0] data,
   output logic [7:0] crc_next
);

   always_comb begin
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ etfd_pkg::CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      crc_next = v;
   end

endmodule

// File: rtl/core/etfd_frame_asm.sv
module etfd_frame_asm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  logic                       frame_start,
   output etfd_pkg::result_type       result
);

   logic [etfd_pkg::POS_W-1:0] pos_ff;
   logic [etfd_pkg::POS_W-1:0] pos_in;
   logic [etfd_pkg::POS_W-1:0] pos_eff;
   logic [7:0]                 crc_ff;
   logic [7:0]                 crc_in;
   logic [7:0]                 crc_eff;
   logic [7:0]                 crc_next;
   logic [7:0]                 frame_ff [etfd_pkg::PAYLOAD_LEN];
   logic                       in_payload;
   logic                       at_crc;

   assign pos_eff    = frame_start ? '0 : pos_ff;
   assign crc_eff    = frame_start ? etfd_pkg::CRC_INIT : crc_ff;
   assign in_payload = pos_eff < etfd_pkg::POS_CRC;
   assign at_crc     = pos_eff == etfd_pkg::POS_CRC;

   etfd_crc8 u_crc8 (
      .crc      (crc_eff),
      .data     (rx_byte),
      .crc_next (crc_next)
   );

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (step) begin
         if (in_payload) begin
            pos_in = etfd_pkg::POS_W'(pos_eff + 1'b1);
            crc_in = crc_next;
         end else if (at_crc) begin
            pos_in = etfd_pkg::POS_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= etfd_pkg::POS_IDLE;
         crc_ff <= etfd_pkg::CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   for (genvar i = 0; i < etfd_pkg::PAYLOAD_LEN; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (step && pos_eff == etfd_pkg::POS_W'(i)) begin
            frame_ff[i] <= rx_byte;
         end
      end
   end

   always_comb begin
      result.valid              = step && at_crc && (rx_byte == crc_eff);
      result.temperature_deg    = frame_ff[0];
      result.voltage_centivolts = {frame_ff[1], frame_ff[2]};
      result.current_centiamps  = {frame_ff[3], frame_ff[4]};
      result.consumption_mah    = {frame_ff[5], frame_ff[6]};
      result.rpm_hundreds       = {frame_ff[7], frame_ff[8]};
   end

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= etfd_pkg::POS_IDLE)
      else $error("frame position out of range");

   a_idle_after_crc: assert property (@(posedge clock) disable iff (reset)
      step && at_crc |=> pos_ff == etfd_pkg::POS_IDLE)
      else $error("not idle after check byte");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      step && frame_start |=> pos_ff == etfd_pkg::POS_W'(1) && crc_ff == $past(crc_next))
      else $error("start byte did not restart frame");
`endif

endmodule
